### src/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Round constants, initial hash value and the round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned ROUNDS = 64;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   typedef struct packed {
      logic start;  // begin compressing the 16 loaded words
      logic init;   // restore the initial hash value
   } core_ctrl_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage
`default_nettype wire

### src/sha256_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression core
// One shared round unit, stepped 64 times per block, with a 16-word
// schedule window and the chaining hash.
// ----------------------------------------------------------------------------
module sha256_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sha256_pkg::core_ctrl_type ctrl,
   input  wire logic [31:0]            load_word,
   input  wire logic                   load_en,
   input  wire logic [2:0]             hash_sel,
   output logic [31:0]                 hash_word,
   output logic                        busy
);

   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [5:0]  round_ff;
   logic        busy_ff;
   logic        fold_ff;

   logic [31:0] w_new, t1, t2, wi;

   assign wi    = w_ff[0];
   assign w_new = w_ff[0] + sha256_pkg::small_sig0(w_ff[1]) + w_ff[9]
                  + sha256_pkg::small_sig1(w_ff[14]);
   assign t1 = v_ff[7] + sha256_pkg::big_sig1(v_ff[4])
               + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
               + sha256_pkg::ROUND_K[round_ff] + wi;
   assign t2 = sha256_pkg::big_sig0(v_ff[0])
               + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign hash_word = h_ff[hash_sel];
   assign busy      = busy_ff | fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fold_ff  <= 1'b0;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::IV[i];
      end else begin
         fold_ff <= 1'b0;
         if (ctrl.init) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::IV[i];
         end
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         end else if (busy_ff) begin
            // advance one round and slide the schedule window
            v_ff[7] <= v_ff[6];
            v_ff[6] <= v_ff[5];
            v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2];
            v_ff[2] <= v_ff[1];
            v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= w_new;
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'(sha256_pkg::ROUNDS - 1)) begin
               busy_ff <= 1'b0;
               fold_ff <= 1'b1;
            end
         end else if (fold_ff) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end
         if (load_en) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= load_word;
         end
      end
   end

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy) else $error("core started while busy");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      load_en |-> !busy_ff) else $error("word loaded during rounds");
   a_fold_after: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> fold_ff) else $error("fold missing after rounds");

endmodule
`default_nettype wire

### src/sha256_hash_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 with padding, length append and digest output.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per handshake; tdata[7:0] is the message byte,
//   tuser[0] says the byte is present, tlast ends the message.
//   rsp channel: after an end item, eight items carry digest words h0..h7
//   (tdata[31:0] word, tdata[34:32] index), tlast on the eighth.
//   Rate: one byte per cycle into the 64-byte buffer while req_tready is
//   high. Each 64th byte holds req_tready low while the single round unit
//   works: the block moves as 16 words into the core, then a start, 64
//   shared rounds, a fold and a hand-back. An end item writes the pad
//   bytes one per cycle up to byte 63, then loads and runs one or two
//   padded blocks, emits eight items and passes a wait state before
//   req_tready returns.
//   Reset clears the fill count, bit count and control and restores the
//   initial hash value. A stalled receiver holds rsp_tdata; the engine waits.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] message_byte
   input  wire logic        req_tuser,   // [0] byte_present
   input  wire logic        req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   output logic             rsp_tlast    // last_word
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_RUN  = 6'b000100,
      ST_PAD  = 6'b001000,
      ST_EMIT = 6'b010000,
      ST_WAIT = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] buf_mem [16];  // block buffer, big-endian bytes per word
   logic [6:0]  fill_ff;       // bytes held, 0..63
   logic [63:0] bits_ff;
   logic        final_ff;      // padding pending or in progress
   logic        lenblk_ff;     // current padded block carries the length
   logic        padded_ff;     // 0x80 already placed
   logic [3:0]  ld_ff;
   logic [2:0]  out_ff;
   logic        start_ff;

   sha256_pkg::core_ctrl_type ctrl;
   logic [31:0] load_word, hash_word;
   logic        load_en, core_busy;

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Each buffer word already holds four bytes in big-endian order.
   assign load_word  = buf_mem[ld_ff];
   assign load_en    = (state_ff == ST_LOAD);
   assign ctrl       = '{start: start_ff,
                         init: (state_ff == ST_EMIT) && rsp_tready && (out_ff == 3'd7)};

   sha256_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .load_word (load_word),
      .load_en   (load_en),
      .hash_sel  (out_ff),
      .hash_word (hash_word),
      .busy      (core_busy)
   );

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {5'd0, out_ff, hash_word};
   assign rsp_tlast  = (out_ff == 3'd7);

   // Byte address written in the pad state: fill position.
   logic [5:0] pad_addr;
   logic [7:0] pad_data;
   assign pad_addr = fill_ff[5:0];
   always_comb begin
      priority if (!padded_ff)            pad_data = sha256_pkg::PAD_BYTE;
      else if (lenblk_ff && fill_ff >= 7'(sha256_pkg::LEN_START))
         pad_data = bits_ff[8*(7 - (fill_ff[2:0])) +: 8];
      else                                pad_data = 8'h00;
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser)
         buf_mem[fill_ff[5:2]][{~fill_ff[1:0], 3'd0} +: 8] <= req_tdata;
      else if (state_ff == ST_PAD)
         buf_mem[pad_addr[5:2]][{~pad_addr[1:0], 3'd0} +: 8] <= pad_data;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_tuser && fill_ff == 7'd63) ) state_in = ST_LOAD;
               else if (req_tlast) state_in = ST_PAD;
            end
         end
         ST_LOAD: if (ld_ff == 4'd15) state_in = ST_RUN;
         ST_RUN: begin
            if (!start_ff && !core_busy) begin
               if (!final_ff)      state_in = ST_IDLE;
               else if (lenblk_ff && padded_ff && fill_ff == 7'd0) state_in = ST_EMIT;
               else                state_in = ST_PAD;
            end
         end
         ST_PAD: if (fill_ff == 7'd63) state_in = ST_LOAD;
         ST_EMIT: if (rsp_tready && out_ff == 3'd7) state_in = ST_WAIT;
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         bits_ff   <= '0;
         final_ff  <= 1'b0;
         lenblk_ff <= 1'b0;
         padded_ff <= 1'b0;
         ld_ff     <= '0;
         out_ff    <= '0;
         start_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == ST_LOAD) && (ld_ff == 4'd15);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser) begin
                     bits_ff <= bits_ff + 64'd8;
                     fill_ff <= (fill_ff == 7'd63) ? 7'd0 : fill_ff + 7'd1;
                  end
                  if (req_tlast) begin
                     final_ff <= 1'b1;
                     // length fits if the 0x80 lands below byte 56
                     lenblk_ff <= req_tuser ?
                        (6'(fill_ff[5:0] + 6'd1) < sha256_pkg::LEN_START)
                        : (fill_ff[5:0] < sha256_pkg::LEN_START);
                  end
               end
               ld_ff <= '0;
            end
            ST_LOAD: ld_ff <= ld_ff + 4'd1;
            ST_RUN: begin
               if (!start_ff && !core_busy && final_ff && padded_ff && fill_ff == 7'd0)
                  lenblk_ff <= 1'b1;
               if (state_in == ST_EMIT) out_ff <= '0;
            end
            ST_PAD: begin
               padded_ff <= 1'b1;
               fill_ff   <= (fill_ff == 7'd63) ? 7'd0 : fill_ff + 7'd1;
               ld_ff     <= '0;
            end
            ST_EMIT: begin
               if (rsp_tready) begin
                  out_ff <= out_ff + 3'd1;
                  if (out_ff == 3'd7) begin
                     fill_ff   <= '0;
                     bits_ff   <= '0;
                     final_ff  <= 1'b0;
                     lenblk_ff <= 1'b0;
                     padded_ff <= 1'b0;
                  end
               end
            end
            ST_WAIT: out_ff <= '0;
            default: ;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      core_busy |-> !req_tready) else $error("ready while core busy");
   a_emit_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> final_ff && padded_ff) else $error("digest without padding");
   a_init_last: assert property (@(posedge clock) disable iff (reset)
      ctrl.init |-> rsp_tlast) else $error("hash reinit before last word");

endmodule
`default_nettype wire

### sim/sha256_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the byte stream and the digest stream, models the hash on every
// accepted item and compares each digest word with the oldest prediction.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] message_byte
   input  wire logic        req_tuser,   // [0] byte_present
   input  wire logic        req_tlast,   // end_of_message
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index
   input  wire logic        rsp_tlast,   // last_word
   output int               fail_count,
   output int               pending_words
);

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   digest_item_type digest_queue[$];
   logic [31:0]  chain[8];
   logic [7:0]   buffer[64];
   int unsigned  fill;
   logic [63:0]  bit_count;

   function automatic logic [31:0] ror32(logic [31:0] v, int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + sha256_pkg::ROUND_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endtask

   task automatic restart();
      for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::IV[i];
      fill      = 0;
      bit_count = '0;
   endtask

   task automatic absorb(logic [7:0] data, logic present, logic finish);
      digest_item_type item;
      if (present) begin
         buffer[fill] = data;
         fill++;
         bit_count += 64'd8;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      end
      if (!finish) return;
      buffer[fill] = sha256_pkg::PAD_BYTE;
      fill++;
      if (fill > 56) begin
         for (int i = fill; i < 64; i++) buffer[i] = 8'h00;
         compress();
         fill = 0;
      end
      for (int i = fill; i < 56; i++) buffer[i] = 8'h00;
      for (int i = 0; i < 8; i++) buffer[56+i] = bit_count[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         item.word  = chain[i];
         item.index = i[2:0];
         item.last  = (i == 7);
         digest_queue.push_back(item);
      end
      restart();
   endtask

   initial begin
      fail_count = 0;
      restart();
   end

   always @(posedge clock) begin
      digest_item_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) absorb(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected digest item %h", rsp_tdata);
               fail_count++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_tdata[31:0] !== want.word) begin
                  $error("digest_word expected %h actual %h", want.word, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[34:32] !== want.index) begin
                  $error("word_index expected %0d actual %0d", want.index, rsp_tdata[34:32]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_word expected %0d actual %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      pending_words = digest_queue.size();
   end
endmodule

### sim/tb_sha256_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Drives directed and random messages under varying back-pressure; the
// digest checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine;
   localparam int IDLE_LIMIT = 20000;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tuser, req_tlast;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [39:0] rsp_tdata;
   int          fail_count, pending_words;
   int          send_idle_pct, recv_idle_pct;
   bit          hold_receiver;
   int          quiet_cycles;

   sha256_hash_engine DUT (.*);
   sha256_digest_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Drive one item; idle at random before offering, hold until accepted.
   task automatic send_item(logic [7:0] data, logic present, logic finish);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= present;
      req_tlast  <= finish;
      do @(posedge clock); while (!req_tready);
   endtask

   // Send a message of random bytes, closing it with a byte or an end-only item.
   task automatic send_message(int length);
      for (int i = 0; i < length - 1; i++) send_item(8'($urandom), 1'b1, 1'b0);
      if (length == 0 || $urandom_range(1)) begin
         if (length > 0) send_item(8'($urandom), 1'b1, 1'b0);
         send_item(8'($urandom), 1'b0, 1'b1);
      end else begin
         send_item(8'($urandom), 1'b1, 1'b1);
      end
   endtask

   // Pause the sender until every predicted digest word has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_receiver) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: count cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      req_tlast = 1'b0; hold_receiver = 1'b0; quiet_cycles = 0;
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, no-op items, extreme bytes, padding edges.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b0);
      send_item(8'ha5, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      drain();
      send_message(56);  // pad spills into a second block
      send_message(64);  // exactly one full block
      drain();

      // Random: sender idles 28, receiver 57; then swapped; then none.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 57 : 0;
         recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 28 : 0;
         if (phase == 2) hold_receiver = 1'b1;  // fill up while rsp is held
         for (int m = 0; m < 6; m++) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_message($urandom_range(0, 4));
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
